FILE: rtl/arq_pkg.sv
package arq_pkg;

    localparam int SCALE_W    = 24;
    localparam int SCALE_FRAC = 24;
    localparam int EPS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd2;

    localparam logic [SCALE_W-1:0] X_SCALE_RST = 24'd54700;
    localparam logic [SCALE_W-1:0] Y_SCALE_RST = 24'd70036;
    localparam logic [EPS_W-1:0]   EPSILON_RST = 16'd1;

    localparam logic FUNC_PRESS = 1'b0;
    localparam logic FUNC_DRAG  = 1'b1;

    localparam int MAP_LAST  = 5;
    localparam int PROD_LAST = 13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_SQRT,
        ST_SQEND,
        ST_DIVX,
        ST_DIVXEND,
        ST_DIVY,
        ST_DIVYEND,
        ST_FIN,
        ST_PROD
    } t_state;

    typedef enum logic [3:0] {
        OPD_ZERO,
        OPD_POSX,
        OPD_POSY,
        OPD_XSC,
        OPD_YSC,
        OPD_X,
        OPD_Y,
        OPD_Z,
        OPD_SX,
        OPD_SY,
        OPD_SZ,
        OPD_CX,
        OPD_CY,
        OPD_CZ,
        OPD_EPS
    } t_opnd;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc;

    typedef enum logic [2:0] {
        CST_NONE,
        CST_CX,
        CST_CY,
        CST_CZ,
        CST_W
    } t_cst;

    typedef struct packed {
        logic  latch_in;
        t_opnd mul_a;
        t_opnd mul_b;
        t_acc  acc;
        logic  ld_x;
        logic  ld_y;
        logic  sq_init;
        logic  sq_step;
        logic  sq_done;
        logic  div_init;
        logic  div_axis;
        logic  div_step;
        logic  div_wr;
        logic  st_start;
        t_cst  cst;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic outside;
        logic out_busy;
    } t_stat;

    localparam t_cmd CMD_NOP = '0;

endpackage

FILE: rtl/arcball_rotation_quaternion.sv
// Arcball pointer-to-rotation block.
// Input channel (i_in_valid / o_in_ready): one pointer event per item, i_func
// selects press (store start vector, no result) or drag (one quaternion result).
// Output channel (o_out_valid / i_out_ready): rot_x/y/z is the cross product of
// start and end vectors, rot_w half their dot product, all signed Q1.FRAC_BITS.
// Config channel (i_cfg_valid / o_cfg_ready): register index 0 x scale, 1 y
// scale, 2 epsilon; always ready, write only while the block is idle.
// One item at a time through a shared multiplier and bit-serial square root
// and divider. A point inside the unit disc needs only the square root; a
// point outside it adds two normalizing divides, and a drag adds the products
// and the epsilon test. The square root and each divide yield F + 2 result
// bits, one per step, with F = FRAC_BITS. Reset clears the start vector to
// zero, restores the register defaults and empties the output register. When
// the receiver stalls, the finished result holds in the output register; the
// next item can be taken and run, and its result waits at the last step until
// the register frees.
module arcball_rotation_quaternion #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [COORD_BITS-1:0]             i_pos_x,
    input  logic [COORD_BITS-1:0]             i_pos_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [FRAC_BITS+1:0]       o_rot_x,
    output logic signed [FRAC_BITS+1:0]       o_rot_y,
    output logic signed [FRAC_BITS+1:0]       o_rot_z,
    output logic signed [FRAC_BITS+1:0]       o_rot_w,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [arq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [arq_pkg::SCALE_W-1:0] r_x_scale;
    logic [arq_pkg::SCALE_W-1:0] r_y_scale;
    logic [arq_pkg::EPS_W-1:0]   r_eps;

    arq_pkg::t_cmd  cmd;
    arq_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale <= arq_pkg::X_SCALE_RST;
            r_y_scale <= arq_pkg::Y_SCALE_RST;
            r_eps     <= arq_pkg::EPSILON_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arq_pkg::CFG_X_SCALE: r_x_scale <= i_cfg_data;
                arq_pkg::CFG_Y_SCALE: r_y_scale <= i_cfg_data;
                arq_pkg::CFG_EPSILON: r_eps     <= i_cfg_data[arq_pkg::EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    arq_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arq_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_func      (i_func),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_x_scale   (r_x_scale),
        .i_y_scale   (r_y_scale),
        .i_eps       (r_eps),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rot_x     (o_rot_x),
        .o_rot_y     (o_rot_y),
        .o_rot_z     (o_rot_z),
        .o_rot_w     (o_rot_w)
    );

endmodule

FILE: rtl/arq_ctrl.sv
module arq_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  arq_pkg::t_stat i_stat,
    output arq_pkg::t_cmd  o_cmd
);

    localparam int NS = FRAC_BITS + 2;
    localparam int SW = $clog2(NS + arq_pkg::PROD_LAST + 2);

    arq_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arq_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step + SW'(1);
        case (r_state)
            arq_pkg::ST_IDLE: begin
                n_step = '0;
                if (i_in_valid) begin
                    n_state = arq_pkg::ST_MAP;
                end
            end
            arq_pkg::ST_MAP: begin
                if (r_step == SW'(arq_pkg::MAP_LAST)) begin
                    n_state = arq_pkg::ST_SQRT;
                    n_step  = '0;
                end
            end
            arq_pkg::ST_SQRT: begin
                if (r_step == SW'(NS - 1)) begin
                    n_state = arq_pkg::ST_SQEND;
                end
            end
            arq_pkg::ST_SQEND: begin
                n_step  = '0;
                n_state = i_stat.outside ? arq_pkg::ST_DIVX : arq_pkg::ST_FIN;
            end
            arq_pkg::ST_DIVX: begin
                if (r_step == SW'(NS - 1)) begin
                    n_state = arq_pkg::ST_DIVXEND;
                end
            end
            arq_pkg::ST_DIVXEND: begin
                n_step  = '0;
                n_state = arq_pkg::ST_DIVY;
            end
            arq_pkg::ST_DIVY: begin
                if (r_step == SW'(NS - 1)) begin
                    n_state = arq_pkg::ST_DIVYEND;
                end
            end
            arq_pkg::ST_DIVYEND: begin
                n_step  = '0;
                n_state = arq_pkg::ST_FIN;
            end
            arq_pkg::ST_FIN: begin
                n_step  = '0;
                n_state = (i_stat.func == arq_pkg::FUNC_DRAG) ? arq_pkg::ST_PROD
                                                               : arq_pkg::ST_IDLE;
            end
            arq_pkg::ST_PROD: begin
                if (r_step == SW'(arq_pkg::PROD_LAST)) begin
                    n_step = r_step;
                    if (!i_stat.out_busy) begin
                        n_state = arq_pkg::ST_IDLE;
                        n_step  = '0;
                    end
                end
            end
            default: begin
                n_state = arq_pkg::ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd      = arq_pkg::CMD_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            arq_pkg::ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            arq_pkg::ST_MAP: begin
                case (r_step)
                    SW'(0): begin
                        o_cmd.mul_a = arq_pkg::OPD_POSX;
                        o_cmd.mul_b = arq_pkg::OPD_XSC;
                    end
                    SW'(1): begin
                        o_cmd.mul_a = arq_pkg::OPD_POSY;
                        o_cmd.mul_b = arq_pkg::OPD_YSC;
                        o_cmd.ld_x  = 1'b1;
                    end
                    SW'(2): begin
                        o_cmd.mul_a = arq_pkg::OPD_X;
                        o_cmd.mul_b = arq_pkg::OPD_X;
                        o_cmd.ld_y  = 1'b1;
                    end
                    SW'(3): begin
                        o_cmd.mul_a = arq_pkg::OPD_Y;
                        o_cmd.mul_b = arq_pkg::OPD_Y;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                    end
                    SW'(4): begin
                        o_cmd.acc = arq_pkg::ACC_ADD;
                    end
                    SW'(5): begin
                        o_cmd.sq_init = 1'b1;
                    end
                    default: begin
                        o_cmd = arq_pkg::CMD_NOP;
                    end
                endcase
            end
            arq_pkg::ST_SQRT: begin
                o_cmd.sq_step = 1'b1;
            end
            arq_pkg::ST_SQEND: begin
                o_cmd.sq_done  = 1'b1;
                o_cmd.div_init = i_stat.outside;
                o_cmd.div_axis = 1'b0;
            end
            arq_pkg::ST_DIVX: begin
                o_cmd.div_step = 1'b1;
            end
            arq_pkg::ST_DIVXEND: begin
                o_cmd.div_wr   = 1'b1;
                o_cmd.div_init = 1'b1;
                o_cmd.div_axis = 1'b1;
            end
            arq_pkg::ST_DIVY: begin
                o_cmd.div_step = 1'b1;
            end
            arq_pkg::ST_DIVYEND: begin
                o_cmd.div_wr = 1'b1;
            end
            arq_pkg::ST_FIN: begin
                o_cmd.st_start = (i_stat.func == arq_pkg::FUNC_PRESS);
            end
            arq_pkg::ST_PROD: begin
                case (r_step)
                    SW'(0): begin
                        o_cmd.mul_a = arq_pkg::OPD_SY;
                        o_cmd.mul_b = arq_pkg::OPD_Z;
                    end
                    SW'(1): begin
                        o_cmd.mul_a = arq_pkg::OPD_SZ;
                        o_cmd.mul_b = arq_pkg::OPD_Y;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                    end
                    SW'(2): begin
                        o_cmd.mul_a = arq_pkg::OPD_SZ;
                        o_cmd.mul_b = arq_pkg::OPD_X;
                        o_cmd.acc   = arq_pkg::ACC_SUB;
                    end
                    SW'(3): begin
                        o_cmd.mul_a = arq_pkg::OPD_SX;
                        o_cmd.mul_b = arq_pkg::OPD_Z;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                        o_cmd.cst   = arq_pkg::CST_CX;
                    end
                    SW'(4): begin
                        o_cmd.mul_a = arq_pkg::OPD_SX;
                        o_cmd.mul_b = arq_pkg::OPD_Y;
                        o_cmd.acc   = arq_pkg::ACC_SUB;
                    end
                    SW'(5): begin
                        o_cmd.mul_a = arq_pkg::OPD_SY;
                        o_cmd.mul_b = arq_pkg::OPD_X;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                        o_cmd.cst   = arq_pkg::CST_CY;
                    end
                    SW'(6): begin
                        o_cmd.mul_a = arq_pkg::OPD_SX;
                        o_cmd.mul_b = arq_pkg::OPD_X;
                        o_cmd.acc   = arq_pkg::ACC_SUB;
                    end
                    SW'(7): begin
                        o_cmd.mul_a = arq_pkg::OPD_SY;
                        o_cmd.mul_b = arq_pkg::OPD_Y;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                        o_cmd.cst   = arq_pkg::CST_CZ;
                    end
                    SW'(8): begin
                        o_cmd.mul_a = arq_pkg::OPD_SZ;
                        o_cmd.mul_b = arq_pkg::OPD_Z;
                        o_cmd.acc   = arq_pkg::ACC_ADD;
                    end
                    SW'(9): begin
                        o_cmd.mul_a = arq_pkg::OPD_CX;
                        o_cmd.mul_b = arq_pkg::OPD_CX;
                        o_cmd.acc   = arq_pkg::ACC_ADD;
                    end
                    SW'(10): begin
                        o_cmd.mul_a = arq_pkg::OPD_CY;
                        o_cmd.mul_b = arq_pkg::OPD_CY;
                        o_cmd.acc   = arq_pkg::ACC_LOAD;
                        o_cmd.cst   = arq_pkg::CST_W;
                    end
                    SW'(11): begin
                        o_cmd.mul_a = arq_pkg::OPD_CZ;
                        o_cmd.mul_b = arq_pkg::OPD_CZ;
                        o_cmd.acc   = arq_pkg::ACC_ADD;
                    end
                    SW'(12): begin
                        o_cmd.mul_a = arq_pkg::OPD_EPS;
                        o_cmd.mul_b = arq_pkg::OPD_EPS;
                        o_cmd.acc   = arq_pkg::ACC_ADD;
                    end
                    SW'(13): begin
                        o_cmd.mul_a    = arq_pkg::OPD_EPS;
                        o_cmd.mul_b    = arq_pkg::OPD_EPS;
                        o_cmd.out_load = !i_stat.out_busy;
                    end
                    default: begin
                        o_cmd = arq_pkg::CMD_NOP;
                    end
                endcase
            end
            default: begin
                o_cmd = arq_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

FILE: rtl/arq_datapath.sv
module arq_datapath #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  arq_pkg::t_cmd                  i_cmd,
    output arq_pkg::t_stat                 o_stat,
    input  logic                           i_func,
    input  logic [COORD_BITS-1:0]          i_pos_x,
    input  logic [COORD_BITS-1:0]          i_pos_y,
    input  logic [arq_pkg::SCALE_W-1:0]    i_x_scale,
    input  logic [arq_pkg::SCALE_W-1:0]    i_y_scale,
    input  logic [arq_pkg::EPS_W-1:0]      i_eps,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [FRAC_BITS+1:0]    o_rot_x,
    output logic signed [FRAC_BITS+1:0]    o_rot_y,
    output logic signed [FRAC_BITS+1:0]    o_rot_z,
    output logic signed [FRAC_BITS+1:0]    o_rot_w
);

    localparam int F   = FRAC_BITS;
    localparam int VW  = F + 2;
    localparam int XW  = F + 3;
    localparam int MW0 = (XW > arq_pkg::SCALE_W + 1) ? XW : arq_pkg::SCALE_W + 1;
    localparam int MW  = (MW0 > COORD_BITS + 1) ? MW0 : COORD_BITS + 1;
    localparam int PW  = 2 * MW;
    localparam int AW  = 2 * F + 5;
    localparam int RW  = 2 * F + 4;
    localparam int QW  = F + 2;
    localparam int SRW = F + 5;
    localparam int DRW = F + 3;
    localparam int NW  = 2 * F + 2;
    localparam int SH  = arq_pkg::SCALE_FRAC - F;

    localparam logic [PW-1:0]        RND_S    = PW'((64'd1 << SH) >> 1);
    localparam logic [PW-1:0]        THREE_S  = PW'(3) << F;
    localparam logic signed [XW-1:0] ONE_X    = XW'(1) << F;
    localparam logic signed [XW-1:0] TWO_X    = XW'(1) << (F + 1);
    localparam logic signed [XW-1:0] NTWO_X   = -(XW'(1) << (F + 1));
    localparam logic [RW-1:0]        ONE_SQ   = RW'(1) << (2 * F);
    localparam logic [QW-1:0]        ONE_Q    = QW'(1) << F;
    localparam logic [AW-1:0]        HALF_C   = AW'(1) << (F - 1);
    localparam logic [AW-1:0]        HALF_W   = AW'(1) << F;
    localparam logic [AW-1:0]        ONE_A    = AW'(1) << F;

    logic                     r_func;
    logic [COORD_BITS-1:0]    r_px, r_py;
    logic signed [XW-1:0]     r_x, r_y, r_z;
    logic signed [VW-1:0]     r_sx, r_sy, r_sz;
    logic signed [VW-1:0]     r_cx, r_cy, r_cz, r_w;
    logic signed [PW-1:0]     r_prod;
    logic signed [AW-1:0]     r_acc;
    logic                     r_outside;
    logic [RW-1:0]            r_rad;
    logic [SRW-1:0]           r_srem;
    logic [QW-1:0]            r_root;
    logic [DRW-1:0]           r_drem;
    logic [QW-1:0]            r_dlo;
    logic [QW-1:0]            r_q;
    logic                     r_dneg;
    logic                     r_ovalid;
    logic signed [VW-1:0]     r_ox, r_oy, r_oz, r_ow;

    logic signed [MW-1:0]     opa, opb;
    logic [PW-1:0]            scaled;
    logic signed [XW-1:0]     sx_val, sy_val;
    logic signed [AW-1:0]     prod_a;
    logic [SRW-1:0]           sq_sh, sq_trial;
    logic [DRW-1:0]           dv_sh;
    logic signed [XW-1:0]     dv_src;
    logic [QW-1:0]            dv_mag;
    logic [NW-1:0]            dv_num;
    logic [QW-1:0]            dv_qc;
    logic signed [XW-1:0]     dv_val;
    logic [AW-1:0]            rs_mag, rs_sum, rs_q;
    logic [F:0]               rs_cl;
    logic signed [VW-1:0]     rs_val;
    logic                     gt_eps;

    function automatic logic signed [MW-1:0] pick(
        input arq_pkg::t_opnd sel,
        input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
        input logic [arq_pkg::SCALE_W-1:0] xs, input logic [arq_pkg::SCALE_W-1:0] ys,
        input logic signed [XW-1:0] x, input logic signed [XW-1:0] y,
        input logic signed [XW-1:0] z,
        input logic signed [VW-1:0] sx, input logic signed [VW-1:0] sy,
        input logic signed [VW-1:0] sz,
        input logic signed [VW-1:0] cx, input logic signed [VW-1:0] cy,
        input logic signed [VW-1:0] cz,
        input logic [arq_pkg::EPS_W-1:0] eps);
        logic signed [MW-1:0] v;
        case (sel)
            arq_pkg::OPD_POSX: v = $signed(MW'(px));
            arq_pkg::OPD_POSY: v = $signed(MW'(py));
            arq_pkg::OPD_XSC:  v = $signed(MW'(xs));
            arq_pkg::OPD_YSC:  v = $signed(MW'(ys));
            arq_pkg::OPD_X:    v = MW'(x);
            arq_pkg::OPD_Y:    v = MW'(y);
            arq_pkg::OPD_Z:    v = MW'(z);
            arq_pkg::OPD_SX:   v = MW'(sx);
            arq_pkg::OPD_SY:   v = MW'(sy);
            arq_pkg::OPD_SZ:   v = MW'(sz);
            arq_pkg::OPD_CX:   v = MW'(cx);
            arq_pkg::OPD_CY:   v = MW'(cy);
            arq_pkg::OPD_CZ:   v = MW'(cz);
            arq_pkg::OPD_EPS:  v = $signed(MW'(eps));
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        opa = pick(i_cmd.mul_a, r_px, r_py, i_x_scale, i_y_scale, r_x, r_y, r_z,
                   r_sx, r_sy, r_sz, r_cx, r_cy, r_cz, i_eps);
        opb = pick(i_cmd.mul_b, r_px, r_py, i_x_scale, i_y_scale, r_x, r_y, r_z,
                   r_sx, r_sy, r_sz, r_cx, r_cy, r_cz, i_eps);

        scaled = ($unsigned(r_prod) + RND_S) >> SH;
        sx_val = (scaled >= THREE_S) ? TWO_X : $signed({1'b0, scaled[F+1:0]}) - ONE_X;
        sy_val = (scaled >= THREE_S) ? NTWO_X : ONE_X - $signed({1'b0, scaled[F+1:0]});

        prod_a = r_prod[AW-1:0];

        sq_sh    = {r_srem[SRW-3:0], r_rad[RW-1:RW-2]};
        sq_trial = SRW'({r_root, 2'b01});

        dv_sh  = {r_drem[DRW-2:0], r_dlo[QW-1]};
        dv_src = i_cmd.div_axis ? r_y : r_x;
        dv_mag = QW'((dv_src < 0) ? -dv_src : dv_src);
        dv_num = NW'({dv_mag, {F{1'b0}}}) + NW'(r_root >> 1);
        dv_qc  = (r_q > ONE_Q) ? ONE_Q : r_q;
        dv_val = r_dneg ? -$signed({1'b0, dv_qc}) : $signed({1'b0, dv_qc});

        rs_mag = (r_acc < 0) ? AW'(-r_acc) : AW'(r_acc);
        rs_sum = rs_mag + ((i_cmd.cst == arq_pkg::CST_W) ? HALF_W : HALF_C);
        rs_q   = (i_cmd.cst == arq_pkg::CST_W) ? (rs_sum >> (F + 1)) : (rs_sum >> F);
        rs_cl  = (rs_q > ONE_A) ? ONE_A[F:0] : rs_q[F:0];
        rs_val = (r_acc < 0) ? -$signed({1'b0, rs_cl}) : $signed({1'b0, rs_cl});

        gt_eps = $signed(PW'(r_acc)) > r_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func <= i_func;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
        end

        r_prod <= opa * opb;

        case (i_cmd.acc)
            arq_pkg::ACC_LOAD: r_acc <= prod_a;
            arq_pkg::ACC_ADD:  r_acc <= r_acc + prod_a;
            arq_pkg::ACC_SUB:  r_acc <= r_acc - prod_a;
            default:           r_acc <= r_acc;
        endcase

        if (i_cmd.ld_x) begin
            r_x <= sx_val;
        end else if (i_cmd.div_wr && i_cmd.div_init) begin
            r_x <= dv_val;
        end
        if (i_cmd.ld_y) begin
            r_y <= sy_val;
        end else if (i_cmd.div_wr && !i_cmd.div_init) begin
            r_y <= dv_val;
        end

        if (i_cmd.sq_init) begin
            r_outside <= r_acc > $signed(AW'(ONE_SQ));
            r_rad     <= (r_acc > $signed(AW'(ONE_SQ))) ? r_acc[RW-1:0]
                                                        : ONE_SQ - r_acc[RW-1:0];
            r_srem    <= '0;
            r_root    <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad <= r_rad << 2;
            if (sq_sh >= sq_trial) begin
                r_srem <= sq_sh - sq_trial;
                r_root <= {r_root[QW-2:0], 1'b1};
            end else begin
                r_srem <= sq_sh;
                r_root <= {r_root[QW-2:0], 1'b0};
            end
        end

        if (i_cmd.sq_done) begin
            r_z <= r_outside ? '0 : $signed(XW'(r_root));
        end

        if (i_cmd.div_init) begin
            r_drem <= DRW'(dv_num >> QW);
            r_dlo  <= dv_num[QW-1:0];
            r_q    <= '0;
            r_dneg <= dv_src < 0;
        end else if (i_cmd.div_step) begin
            r_dlo <= r_dlo << 1;
            if (dv_sh >= DRW'(r_root)) begin
                r_drem <= dv_sh - DRW'(r_root);
                r_q    <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_drem <= dv_sh;
                r_q    <= {r_q[QW-2:0], 1'b0};
            end
        end

        case (i_cmd.cst)
            arq_pkg::CST_CX: r_cx <= rs_val;
            arq_pkg::CST_CY: r_cy <= rs_val;
            arq_pkg::CST_CZ: r_cz <= rs_val;
            arq_pkg::CST_W:  r_w  <= rs_val;
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            r_ox <= gt_eps ? r_cx : '0;
            r_oy <= gt_eps ? r_cy : '0;
            r_oz <= gt_eps ? r_cz : '0;
            r_ow <= gt_eps ? r_w  : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.st_start) begin
                r_sx <= r_x[VW-1:0];
                r_sy <= r_y[VW-1:0];
                r_sz <= r_z[VW-1:0];
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.outside  = r_outside;
    assign o_stat.out_busy = r_ovalid && !i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_rot_x     = r_ox;
    assign o_rot_y     = r_oy;
    assign o_rot_z     = r_oz;
    assign o_rot_w     = r_ow;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CB = 12;
    localparam int FB = 16;
    localparam int VW = FB + 2;
    localparam longint ONE = 64'sd1 << FB;
    localparam int IDLE_WAIT = 150;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [arq_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic signed [VW-1:0] w;
    } t_quat;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic i_func;
    logic [CB-1:0] i_pos_x;
    logic [CB-1:0] i_pos_y;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [VW-1:0] o_rot_x;
    logic signed [VW-1:0] o_rot_y;
    logic signed [VW-1:0] o_rot_z;
    logic signed [VW-1:0] o_rot_w;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [arq_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [arq_pkg::CFG_DATA_W-1:0] i_cfg_data;

    arcball_rotation_quaternion #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

    logic [arq_pkg::SCALE_W-1:0] mdl_x_scale;
    logic [arq_pkg::SCALE_W-1:0] mdl_y_scale;
    logic [arq_pkg::EPS_W-1:0] mdl_eps;
    longint anchor_x, anchor_y, anchor_z;
    t_quat rot_queue[$];
    int errors;
    longint cycles;
    bit hold_off;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'sd1 << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint half;
        half = 64'sd1 << (s - 1);
        if (v < 0) return -((-v + half) >>> s);
        return (v + half) >>> s;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = n < 0 ? -n : n;
        q = (m + d / 2) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic longint scaled(logic [CB-1:0] pos, logic [arq_pkg::SCALE_W-1:0] sc);
        longint p;
        int sh;
        sh = arq_pkg::SCALE_FRAC - FB;
        p = longint'(pos) * longint'(sc);
        return (p + ((64'sd1 << sh) >>> 1)) >>> sh;
    endfunction

    task automatic sphere_point(input logic [CB-1:0] px, input logic [CB-1:0] py,
                                output longint vx, output longint vy, output longint vz);
        longint x, y, l2, r;
        x = clip(scaled(px, mdl_x_scale) - ONE, -2 * ONE, 2 * ONE);
        y = clip(ONE - scaled(py, mdl_y_scale), -2 * ONE, 2 * ONE);
        l2 = x * x + y * y;
        if (l2 > ONE * ONE) begin
            r = isqrt(l2);
            vx = clip(round_div(x * ONE, r), -ONE, ONE);
            vy = clip(round_div(y * ONE, r), -ONE, ONE);
            vz = 0;
        end else begin
            vx = x;
            vy = y;
            vz = isqrt(ONE * ONE - l2);
        end
    endtask

    task automatic predict_rotation(input logic fn, input logic [CB-1:0] px,
                                    input logic [CB-1:0] py);
        longint ex, ey, ez, cx, cy, cz, w;
        t_quat q;
        if (fn == arq_pkg::FUNC_PRESS) begin
            sphere_point(px, py, anchor_x, anchor_y, anchor_z);
        end else begin
            sphere_point(px, py, ex, ey, ez);
            cx = clip(round_shift(anchor_y * ez - anchor_z * ey, FB), -ONE, ONE);
            cy = clip(round_shift(anchor_z * ex - anchor_x * ez, FB), -ONE, ONE);
            cz = clip(round_shift(anchor_x * ey - anchor_y * ex, FB), -ONE, ONE);
            w = clip(round_shift(anchor_x * ex + anchor_y * ey + anchor_z * ez, FB + 1),
                     -ONE, ONE);
            if (cx * cx + cy * cy + cz * cz > longint'(mdl_eps) * longint'(mdl_eps)) begin
                q.x = VW'(cx);
                q.y = VW'(cy);
                q.z = VW'(cz);
                q.w = VW'(w);
            end else begin
                q = '0;
            end
            rot_queue.push_back(q);
        end
    endtask

    task automatic send_event(input logic fn, input logic [CB-1:0] px,
                              input logic [CB-1:0] py);
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_pos_x <= px;
        i_pos_y <= py;
        predict_rotation(fn, px, py);
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    int burst_left;

    task automatic send_paced(input logic fn, input logic [CB-1:0] px,
                              input logic [CB-1:0] py);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
        burst_left--;
        send_event(fn, px, py);
    endtask

    task automatic drain_and_idle();
        while (rot_queue.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [arq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arq_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            arq_pkg::CFG_X_SCALE: mdl_x_scale = d;
            arq_pkg::CFG_Y_SCALE: mdl_y_scale = d;
            arq_pkg::CFG_EPSILON: mdl_eps = d[arq_pkg::EPS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [CB-1:0] mx;
        mx = '1;
        send_event(arq_pkg::FUNC_DRAG, 12'd100, 12'd200);
        send_event(arq_pkg::FUNC_PRESS, 12'd0, 12'd0);
        send_event(arq_pkg::FUNC_DRAG, mx, mx);
        send_event(arq_pkg::FUNC_DRAG, 12'd0, 12'd0);
        send_event(arq_pkg::FUNC_PRESS, 12'd1200, 12'd468);
        send_event(arq_pkg::FUNC_DRAG, 12'd1200, 12'd468);
        send_event(arq_pkg::FUNC_DRAG, 12'd1300, 12'd500);
        send_event(arq_pkg::FUNC_DRAG, mx, 12'd0);
        send_event(arq_pkg::FUNC_DRAG, 12'd0, mx);
        send_event(arq_pkg::FUNC_PRESS, 12'd1199, 12'd935);
        send_event(arq_pkg::FUNC_DRAG, 12'd1199, 12'd0);
        send_event(arq_pkg::FUNC_DRAG, 12'd2048, 12'd2048);
        drain_and_idle();
        write_reg(arq_pkg::CFG_X_SCALE, 24'hFFFFFF);
        write_reg(arq_pkg::CFG_Y_SCALE, 24'hFFFFFF);
        write_reg(CFG_UNUSED, 24'h123456);
        send_event(arq_pkg::FUNC_PRESS, 12'd1, 12'd1);
        send_event(arq_pkg::FUNC_DRAG, mx, 12'd0);
        send_event(arq_pkg::FUNC_DRAG, 12'd0, 12'd0);
        drain_and_idle();
        write_reg(arq_pkg::CFG_X_SCALE, 24'd0);
        write_reg(arq_pkg::CFG_Y_SCALE, 24'd0);
        write_reg(arq_pkg::CFG_EPSILON, 24'hFFFF);
        send_event(arq_pkg::FUNC_PRESS, 12'd5, 12'd7);
        send_event(arq_pkg::FUNC_DRAG, mx, mx);
        drain_and_idle();
        write_reg(arq_pkg::CFG_EPSILON, 24'd0);
        send_event(arq_pkg::FUNC_DRAG, 12'd3, 12'd4);
        drain_and_idle();
    endtask

    task automatic random_phase(input int n, input int dim_x, input int dim_y);
        logic [CB-1:0] px, py;
        logic fn;
        for (int k = 0; k < n; k++) begin
            fn = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                px = CB'($urandom);
                py = CB'($urandom);
            end else begin
                px = CB'($urandom_range(0, dim_x));
                py = CB'($urandom_range(0, dim_y));
            end
            send_paced(fn, px, py);
        end
    endtask

    task automatic test_random();
        write_reg(arq_pkg::CFG_X_SCALE, 24'd54700);
        write_reg(arq_pkg::CFG_Y_SCALE, 24'd70036);
        write_reg(arq_pkg::CFG_EPSILON, 24'd1);
        random_phase(600, 1250, 960);
        drain_and_idle();
        write_reg(arq_pkg::CFG_X_SCALE, 24'd8196);
        write_reg(arq_pkg::CFG_Y_SCALE, 24'd8196);
        write_reg(arq_pkg::CFG_EPSILON, 24'd2000);
        random_phase(500, 4095, 4095);
        drain_and_idle();
        write_reg(arq_pkg::CFG_X_SCALE, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(arq_pkg::CFG_Y_SCALE, 24'($urandom_range(0, 200000)));
        write_reg(arq_pkg::CFG_EPSILON, 24'($urandom_range(0, 16'hFFFF)));
        random_phase(300, 4095, 4095);
        drain_and_idle();
        write_reg(arq_pkg::CFG_X_SCALE, 24'd54700);
        write_reg(arq_pkg::CFG_Y_SCALE, 24'd70036);
        write_reg(arq_pkg::CFG_EPSILON, 24'd300);
        random_phase(420, 1250, 960);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        repeat (2) @(posedge i_clk);
        hold_off = 1'b0;
        for (int k = 0; k < 6; k++)
            send_event(arq_pkg::FUNC_DRAG, CB'($urandom_range(0, 1250)),
                       CB'($urandom_range(0, 960)));
        drain_and_idle();
    endtask

    int stall_cnt;
    int hold_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_cnt <= 0;
            hold_cnt <= 0;
        end else if (hold_off || hold_cnt != 0) begin
            i_out_ready <= 1'b0;
            hold_cnt <= hold_off ? 400 : hold_cnt - 1;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt[9]) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge i_clk) begin
        t_quat q;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rot_queue.size() == 0) begin
                $error("unexpected rotation item");
                errors++;
            end else begin
                q = rot_queue.pop_front();
                if (o_rot_x !== q.x) begin
                    $error("rot_x expected %0d actual %0d", q.x, o_rot_x);
                    errors++;
                end
                if (o_rot_y !== q.y) begin
                    $error("rot_y expected %0d actual %0d", q.y, o_rot_y);
                    errors++;
                end
                if (o_rot_z !== q.z) begin
                    $error("rot_z expected %0d actual %0d", q.z, o_rot_z);
                    errors++;
                end
                if (o_rot_w !== q.w) begin
                    $error("rot_w expected %0d actual %0d", q.w, o_rot_w);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = arq_pkg::FUNC_PRESS;
        i_pos_x = '0;
        i_pos_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = arq_pkg::CFG_X_SCALE;
        i_cfg_data = '0;
        mdl_x_scale = arq_pkg::X_SCALE_RST;
        mdl_y_scale = arq_pkg::Y_SCALE_RST;
        mdl_eps = arq_pkg::EPSILON_RST;
        anchor_x = 0;
        anchor_y = 0;
        anchor_z = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random();
        while (rot_queue.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (errors == 0 && rot_queue.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/arq_pkg.sv
rtl/arq_ctrl.sv
rtl/arq_datapath.sv
rtl/arcball_rotation_quaternion.sv
tb/tb_top.sv
